### rtl/frd_pkg.sv
package frd_pkg;

    localparam logic [7:0] REC_BEGIN  = 8'd1;
    localparam logic [7:0] REC_END    = 8'd3;
    localparam logic [7:0] REC_PARAMS = 8'd4;
    localparam logic [7:0] REC_STDIN  = 8'd5;
    localparam logic [7:0] REC_STDOUT = 8'd6;
    localparam logic [7:0] REC_DATA   = 8'd8;

    localparam int unsigned LEN_W = 31;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_CONTENT = 2'd1;
    localparam logic [1:0] PH_PADDING = 2'd2;

    localparam logic [1:0] PP_KEYLEN = 2'd0;
    localparam logic [1:0] PP_VALLEN = 2'd1;
    localparam logic [1:0] PP_KEY    = 2'd2;
    localparam logic [1:0] PP_VALUE  = 2'd3;

    localparam logic [3:0] KIND_HEADER  = 4'd0;
    localparam logic [3:0] KIND_BEGIN   = 4'd1;
    localparam logic [3:0] KIND_KEYLEN  = 4'd2;
    localparam logic [3:0] KIND_VALLEN  = 4'd3;
    localparam logic [3:0] KIND_KEY     = 4'd4;
    localparam logic [3:0] KIND_VALUE   = 4'd5;
    localparam logic [3:0] KIND_PAYLOAD = 4'd6;
    localparam logic [3:0] KIND_PADDING = 4'd7;
    localparam logic [3:0] KIND_SKIPPED = 4'd8;

    typedef struct packed {
        logic [3:0]       kind;
        logic             done;
        logic [LEN_W-1:0] flen;
    } pair_result_t;

    typedef struct packed {
        logic [3:0]       byte_kind;
        logic [7:0]       data_byte;
        logic [7:0]       record_type;
        logic [15:0]      record_id;
        logic [15:0]      body_len;
        logic [7:0]       pad_len;
        logic [15:0]      role;
        logic [7:0]       begin_flags;
        logic [LEN_W-1:0] field_length;
        logic             field_done;
        logic             record_last;
        logic             end_request;
    } frd_result_t;

endpackage

### rtl/frd_if.sv
interface frd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface frd_out_if import frd_pkg::*; ();
    logic        valid;
    logic        ready;
    frd_result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/frd_pair_decoder.sv
module frd_pair_decoder
    import frd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic         clear,
    input  logic [7:0]   stream_byte,
    output pair_result_t result
);

    logic [1:0]       phase_reg, phase_next;
    logic [1:0]       bytes_left_reg, bytes_left_next;
    logic [LEN_W-1:0] acc_reg, acc_next;
    logic [LEN_W-1:0] key_left_reg, key_left_next;
    logic [LEN_W-1:0] value_left_reg, value_left_next;
    logic [LEN_W-1:0] key_dec;
    logic [LEN_W-1:0] value_dec;
    logic             fin;

    assign key_dec   = key_left_reg - LEN_W'(key_left_reg != '0);
    assign value_dec = value_left_reg - LEN_W'(value_left_reg != '0);

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        acc_next        = acc_reg;
        key_left_next   = key_left_reg;
        value_left_next = value_left_reg;
        fin             = 1'b0;
        result.kind     = KIND_KEYLEN;
        result.done     = 1'b0;
        result.flen     = '0;
        unique case (phase_reg) inside
            PP_KEYLEN, PP_VALLEN:
            begin
                result.kind = (phase_reg == PP_KEYLEN) ? KIND_KEYLEN : KIND_VALLEN;
                if (bytes_left_reg == 2'd0)
                begin
                    if (stream_byte[7])
                    begin
                        acc_next        = LEN_W'(stream_byte[6:0]);
                        bytes_left_next = 2'd3;
                    end
                    else
                    begin
                        acc_next = LEN_W'(stream_byte);
                        fin      = 1'b1;
                    end
                end
                else
                begin
                    acc_next        = {acc_reg[LEN_W-9:0], stream_byte};
                    bytes_left_next = bytes_left_reg - 2'd1;
                    fin             = (bytes_left_reg == 2'd1);
                end
                result.flen = acc_next;
                result.done = fin;
                if (fin)
                begin
                    if (phase_reg == PP_KEYLEN)
                    begin
                        key_left_next = acc_next;
                        phase_next    = PP_VALLEN;
                    end
                    else
                    begin
                        value_left_next = acc_next;
                        if (key_left_reg != '0)
                            phase_next = PP_KEY;
                        else if (acc_next != '0)
                            phase_next = PP_VALUE;
                        else
                            phase_next = PP_KEYLEN;
                    end
                end
            end
            PP_KEY:
            begin
                result.kind   = KIND_KEY;
                key_left_next = key_dec;
                if (key_dec == '0)
                    phase_next = (value_left_reg != '0) ? PP_VALUE : PP_KEYLEN;
            end
            default:
            begin
                result.kind     = KIND_VALUE;
                value_left_next = value_dec;
                if (value_dec == '0)
                    phase_next = PP_KEYLEN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PP_KEYLEN;
            bytes_left_reg <= 2'd0;
            acc_reg        <= '0;
            key_left_reg   <= '0;
            value_left_reg <= '0;
        end
        else if (clear)
        begin
            phase_reg      <= PP_KEYLEN;
            bytes_left_reg <= 2'd0;
            acc_reg        <= '0;
            key_left_reg   <= '0;
            value_left_reg <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            acc_reg        <= acc_next;
            key_left_reg   <= key_left_next;
            value_left_reg <= value_left_next;
        end
    end

endmodule

### rtl/fastcgi_record_deframer.sv
// FastCGI record deframer: takes one stream byte per beat and returns one
// classified result beat per byte, with the current record header fields, the
// latest begin-request role and flags, and decoded name-value lengths. Every
// byte is handled combinationally between the input handshake and one output
// register, so a byte can be taken every clock cycle; the input stalls only
// while the output register holds a beat the sink has not taken. Results are
// registered, valid in the cycle after the byte is accepted. An END_REQUEST
// header ends its record at once and the next byte starts a new header.
module fastcgi_record_deframer
    import frd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    frd_in_if.sink    bytes,
    frd_out_if.source results
);

    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  header_index_reg, header_index_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] request_reg, request_next;
    logic [15:0] content_reg, content_next;
    logic [7:0]  padding_reg, padding_next;
    logic [15:0] content_left_reg, content_left_next;
    logic [7:0]  padding_left_reg, padding_left_next;
    logic [3:0]  body_index_reg, body_index_next;
    logic [15:0] role_reg, role_next;
    logic [7:0]  flags_reg, flags_next;
    logic        out_valid_reg;
    frd_result_t out_reg;
    frd_result_t result;

    logic        accept;
    logic        pair_step;
    logic        pair_clear;
    logic [7:0]  b;
    logic [15:0] content_dec;
    logic [7:0]  padding_dec;
    pair_result_t pair;

    assign b            = bytes.stream_byte;
    assign bytes.ready  = !out_valid_reg || results.ready;
    assign accept       = bytes.valid && bytes.ready;
    assign content_dec  = content_left_reg - 16'(content_left_reg != 16'd0);
    assign padding_dec  = padding_left_reg - 8'(padding_left_reg != 8'd0);

    frd_pair_decoder u_pair (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept && pair_step),
        .clear       (accept && pair_clear),
        .stream_byte (b),
        .result      (pair)
    );

    always_comb
    begin
        phase_next        = phase_reg;
        header_index_next = header_index_reg;
        type_next         = type_reg;
        request_next      = request_reg;
        content_next      = content_reg;
        padding_next      = padding_reg;
        content_left_next = content_left_reg;
        padding_left_next = padding_left_reg;
        body_index_next   = body_index_reg;
        role_next         = role_reg;
        flags_next        = flags_reg;
        pair_step         = 1'b0;
        pair_clear        = 1'b0;
        result.byte_kind    = KIND_HEADER;
        result.field_length = '0;
        result.field_done   = 1'b0;
        result.record_last  = 1'b0;
        result.end_request  = 1'b0;

        unique case (phase_reg)
            PH_CONTENT:
            begin
                if (type_reg == REC_BEGIN)
                begin
                    if (body_index_reg < 4'd8)
                    begin
                        result.byte_kind = KIND_BEGIN;
                        case (body_index_reg)
                            4'd0:    role_next[15:8] = b;
                            4'd1:    role_next[7:0]  = b;
                            4'd2:    flags_next      = b;
                            default: ;
                        endcase
                        result.field_done = (body_index_reg == 4'd7);
                        body_index_next   = body_index_reg + 4'd1;
                    end
                    else
                        result.byte_kind = KIND_SKIPPED;
                end
                else if (type_reg == REC_PARAMS)
                begin
                    pair_step           = 1'b1;
                    result.byte_kind    = pair.kind;
                    result.field_done   = pair.done;
                    result.field_length = pair.flen;
                end
                else if (type_reg == REC_STDIN || type_reg == REC_STDOUT ||
                         type_reg == REC_DATA)
                    result.byte_kind = KIND_PAYLOAD;
                else
                    result.byte_kind = KIND_SKIPPED;

                content_left_next = content_dec;
                if (content_dec == 16'd0)
                begin
                    if (padding_reg != 8'd0)
                    begin
                        padding_left_next = padding_reg;
                        phase_next        = PH_PADDING;
                    end
                    else
                    begin
                        phase_next         = PH_HEADER;
                        result.record_last = 1'b1;
                    end
                end
            end
            PH_PADDING:
            begin
                result.byte_kind  = KIND_PADDING;
                padding_left_next = padding_dec;
                if (padding_dec == 8'd0)
                begin
                    phase_next         = PH_HEADER;
                    result.record_last = 1'b1;
                end
            end
            default:
            begin
                result.byte_kind = KIND_HEADER;
                case (header_index_reg)
                    3'd0:
                    begin
                        type_next    = 8'd0;
                        request_next = 16'd0;
                        content_next = 16'd0;
                        padding_next = 8'd0;
                    end
                    3'd1:    type_next          = b;
                    3'd2:    request_next[15:8] = b;
                    3'd3:    request_next[7:0]  = b;
                    3'd4:    content_next[15:8] = b;
                    3'd5:    content_next[7:0]  = b;
                    3'd6:    padding_next       = b;
                    default: ;
                endcase
                header_index_next = header_index_reg + 3'd1;
                phase_next        = PH_HEADER;
                if (header_index_reg == 3'd7)
                begin
                    result.field_done = 1'b1;
                    body_index_next   = 4'd0;
                    if (type_reg == REC_END)
                    begin
                        result.end_request = 1'b1;
                        result.record_last = 1'b1;
                        pair_clear         = 1'b1;
                    end
                    else if (content_reg != 16'd0)
                    begin
                        content_left_next = content_reg;
                        phase_next        = PH_CONTENT;
                    end
                    else if (padding_reg != 8'd0)
                    begin
                        padding_left_next = padding_reg;
                        phase_next        = PH_PADDING;
                    end
                    else
                        result.record_last = 1'b1;
                end
            end
        endcase

        result.data_byte   = b;
        result.record_type = type_next;
        result.record_id   = request_next;
        result.body_len    = content_next;
        result.pad_len     = padding_next;
        result.role        = role_next;
        result.begin_flags = flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            header_index_reg <= 3'd0;
            type_reg         <= 8'd0;
            request_reg      <= 16'd0;
            content_reg      <= 16'd0;
            padding_reg      <= 8'd0;
            content_left_reg <= 16'd0;
            padding_left_reg <= 8'd0;
            body_index_reg   <= 4'd0;
            role_reg         <= 16'd0;
            flags_reg        <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            header_index_reg <= header_index_next;
            type_reg         <= type_next;
            request_reg      <= request_next;
            content_reg      <= content_next;
            padding_reg      <= padding_next;
            content_left_reg <= content_left_next;
            padding_left_reg <= padding_left_next;
            body_index_reg   <= body_index_next;
            role_reg         <= role_next;
            flags_reg        <= flags_next;
        end
    end

    // hold the result beat until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= result;
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_reg;

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("record phase left its legal codes");

    a_end_request: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.end_request |->
            out_reg.record_last && out_reg.field_done &&
            out_reg.byte_kind == KIND_HEADER && out_reg.record_type == REC_END)
        else $error("end_request beat is not a completed END_REQUEST header");

    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.field_done |->
            out_reg.byte_kind == KIND_HEADER || out_reg.byte_kind == KIND_BEGIN ||
            out_reg.byte_kind == KIND_KEYLEN || out_reg.byte_kind == KIND_VALLEN)
        else $error("field_done on a byte that closes no field");

    a_flen_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.field_length != '0 |->
            out_reg.byte_kind == KIND_KEYLEN || out_reg.byte_kind == KIND_VALLEN)
        else $error("field_length set on a byte that is not a length byte");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !results.ready |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result beat changed or vanished");

endmodule
